// ===== hdl/four_channel_tone_noise_mixer_defines.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef FOUR_CHANNEL_TONE_NOISE_MIXER_DEFINES_SVH
`define FOUR_CHANNEL_TONE_NOISE_MIXER_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define FCTNM_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fctnm: invariant violated");

// The consequence must hold in the same cycle as the condition.
`define FCTNM_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("fctnm: same-cycle implication violated");

// The consequence must hold in the cycle after the condition.
`define FCTNM_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("fctnm: next-cycle implication violated");

`endif

// ===== hdl/fctnm_pkg.sv =====
// Shared widths and divider interface types for the tone and noise mixer.
package fctnm_pkg;

    localparam int DIV_W = 19;
    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_stat_t;

endpackage

// ===== hdl/fctnm_div.sv =====
// Bit-serial restoring divider giving quotient and remainder, one bit per cycle.
module fctnm_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fctnm_pkg::div_ctrl_t  ctrl,
    output fctnm_pkg::div_stat_t  stat
);
    import fctnm_pkg::*;

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W-1:0] dsr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        fits    = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = ctrl.dividend;
            dsr_next  = ctrl.divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

// ===== hdl/four_channel_tone_noise_mixer.sv =====
// Four-channel square-wave and noise mixer with a bit-serial shared divider.
// A set request with a nonzero frequency waits for the period from a 19-step serial division.
// A sample request steps the counters, then adds one serial division for each channel whose
// counter sits at or above a newly lowered period, before the mix state.
// One request is worked on at a time; a finished sample waits in an output register.
// Reset zeroes counters, half periods and levels, sets periods and noise to 1, rate to 22050.
`include "four_channel_tone_noise_mixer_defines.svh"

module four_channel_tone_noise_mixer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel [1:0], frequency [19:2], volume [27:20], zero pad
    input  logic        s_tuser,   // action: 0 set channel, 1 produce sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // sample [7:0]
    input  logic        cfg_we,
    input  logic [17:0] cfg_data
);
    import fctnm_pkg::*;

    localparam int          NUM_CH        = 4;
    localparam int          NOISE_CH      = 3;
    localparam int          NOISE_TOP_BIT = 31;
    localparam logic [31:0] NOISE_TAP     = 32'h0004_0001;
    localparam logic [7:0]  MID_LEVEL     = 8'd128;
    localparam logic [7:0]  MAX_LEVEL     = 8'd31;
    localparam logic [17:0] RATE_RESET    = 18'd22050;

    localparam logic ACT_SET    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SET_WAIT = 3'd1;
    localparam logic [2:0] ST_MOD_PICK = 3'd2;
    localparam logic [2:0] ST_MOD_WAIT = 3'd3;
    localparam logic [2:0] ST_MIX      = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [17:0]                  rate_reg;
    logic [17:0]                  rate_next;
    logic [NUM_CH-1:0][17:0]      pc_reg;
    logic [NUM_CH-1:0][17:0]      pc_next;
    logic [NUM_CH-1:0][18:0]      period_reg;
    logic [NUM_CH-1:0][18:0]      period_next;
    logic [NUM_CH-1:0][17:0]      half_reg;
    logic [NUM_CH-1:0][17:0]      half_next;
    logic [NUM_CH-1:0][4:0]       level_reg;
    logic [NUM_CH-1:0][4:0]       level_next;
    logic [31:0]                  noise_reg;
    logic [31:0]                  noise_next;
    logic [NUM_CH-1:0]            pend_reg;
    logic [NUM_CH-1:0]            pend_next;
    logic [1:0]                   ch_reg;
    logic [1:0]                   ch_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [7:0]                   out_data_reg;
    logic [7:0]                   out_data_next;

    div_ctrl_t                    div_ctrl;
    div_stat_t                    div_stat;

    logic [1:0]                   in_ch;
    logic [17:0]                  in_freq;
    logic [7:0]                   in_vol;
    logic [17:0]                  clamp_freq;
    logic [4:0]                   sat_vol;
    logic [18:0]                  inc;
    logic [18:0]                  q_plus;
    logic [1:0]                   pick;
    logic [31:0]                  noise_shifted;
    logic [31:0]                  noise_stepped;
    logic [7:0]                   acc;
    logic                         div_waiting;
    logic                         mix_fire;

    assign in_ch   = s_tdata[1:0];
    assign in_freq = s_tdata[19:2];
    assign in_vol  = s_tdata[27:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign div_waiting = (state_reg == ST_SET_WAIT) || (state_reg == ST_MOD_WAIT);
    assign mix_fire    = (state_reg == ST_MIX) && (!m_tvalid || m_tready);

    fctnm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    always_comb
    begin
        clamp_freq = (in_freq > rate_reg) ? rate_reg : in_freq;
        sat_vol    = (in_vol > MAX_LEVEL) ? MAX_LEVEL[4:0] : in_vol[4:0];
        q_plus     = div_stat.quotient + 19'd1;

        pick = 2'd0;
        for (int i = NUM_CH - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick = 2'(i);
            end
        end

        noise_shifted = {noise_reg[30:0], 1'b0};
        if (noise_shifted[NOISE_TOP_BIT])
        begin
            noise_shifted = noise_shifted ^ NOISE_TAP;
        end
        noise_stepped = (pc_reg[NOISE_CH] == 18'd0) ? noise_shifted : noise_reg;

        acc = MID_LEVEL;
        for (int i = 0; i < NOISE_CH; i++)
        begin
            if (pc_reg[i] < half_reg[i])
            begin
                acc = acc + 8'(level_reg[i]);
            end
            else
            begin
                acc = acc - 8'(level_reg[i]);
            end
        end
        if (noise_stepped[0])
        begin
            acc = acc + 8'(level_reg[NOISE_CH]);
        end
        else
        begin
            acc = acc - 8'(level_reg[NOISE_CH]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rate_next      = cfg_we ? cfg_data : rate_reg;
        pc_next        = pc_reg;
        period_next    = period_reg;
        half_next      = half_reg;
        level_next     = level_reg;
        noise_next     = noise_reg;
        pend_next      = pend_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        inc            = '0;

        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = {1'b0, rate_reg};
        div_ctrl.divisor  = {1'b0, clamp_freq};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_SAMPLE)
                    begin
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            inc = {1'b0, pc_reg[i]} + 19'd1;
                            if (inc < period_reg[i])
                            begin
                                pc_next[i] = inc[17:0];
                            end
                            else if (inc == period_reg[i])
                            begin
                                pc_next[i] = 18'd0;
                            end
                            else
                            begin
                                pend_next[i] = 1'b1;
                            end
                        end
                        state_next = ST_MOD_PICK;
                    end
                    else if (clamp_freq == 18'd0)
                    begin
                        period_next[in_ch] = 19'd1;
                        half_next[in_ch]   = 18'd0;
                        level_next[in_ch]  = 5'd0;
                    end
                    else
                    begin
                        level_next[in_ch] = sat_vol;
                        ch_next           = in_ch;
                        div_ctrl.start    = 1'b1;
                        state_next        = ST_SET_WAIT;
                    end
                end
            end
            ST_SET_WAIT:
            begin
                if (div_stat.done)
                begin
                    period_next[ch_reg] = q_plus;
                    half_next[ch_reg]   = q_plus[18:1];
                    state_next          = ST_IDLE;
                end
            end
            ST_MOD_PICK:
            begin
                if (pend_reg != '0)
                begin
                    div_ctrl.start    = 1'b1;
                    div_ctrl.dividend = {1'b0, pc_reg[pick]} + 19'd1;
                    div_ctrl.divisor  = period_reg[pick];
                    ch_next           = pick;
                    state_next        = ST_MOD_WAIT;
                end
                else
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MOD_WAIT:
            begin
                if (div_stat.done)
                begin
                    pc_next[ch_reg]   = div_stat.remainder[17:0];
                    pend_next[ch_reg] = 1'b0;
                    state_next        = ST_MOD_PICK;
                end
            end
            ST_MIX:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    noise_next     = noise_stepped;
                    out_data_next  = acc;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            pc_reg        <= '0;
            period_reg    <= {NUM_CH{19'd1}};
            half_reg      <= '0;
            level_reg     <= '0;
            noise_reg     <= 32'd1;
            pend_reg      <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            pc_reg        <= pc_next;
            period_reg    <= period_next;
            half_reg      <= half_next;
            level_reg     <= level_next;
            noise_reg     <= noise_next;
            pend_reg      <= pend_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `FCTNM_ASSERT_SAME(a_ready_div_idle, s_tready, !div_stat.busy)
    `FCTNM_ASSERT_SAME(a_done_in_wait, div_stat.done, div_waiting)
    `FCTNM_ASSERT_NEXT(a_mix_loads_out, mix_fire, m_tvalid && (state_reg == ST_IDLE))
    `FCTNM_ASSERT_HOLDS(a_noise_half_below, {1'b0, half_reg[NOISE_CH]} < period_reg[NOISE_CH])

endmodule
